/* rtl/env_sensor_integer_compensation_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the environmental sensor compensation block
// Clocked assertion helpers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef ENV_SENSOR_INTEGER_COMPENSATION_MACROS_SVH
`define ENV_SENSOR_INTEGER_COMPENSATION_MACROS_SVH

// check a property outside reset
`define ESIC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("esic assertion failed");

// check a property at every edge, reset included
`define ESIC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("esic assertion failed");

`endif

/* rtl/esic_pkg.sv */
// ----------------------------------------------------------------------------
// esic_pkg
// Types, constants and helpers for the sensor compensation datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package esic_pkg;

  typedef logic signed [31:0] s32_t;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_TEMP_CAL    = 3'd0,
    REG_PRESS_CAL_A = 3'd1,
    REG_PRESS_CAL_B = 3'd2,
    REG_PRESS_CAL_C = 3'd3,
    REG_HUM_CAL_A   = 3'd4,
    REG_HUM_CAL_B   = 3'd5
  } reg_idx_t;

  // calibration coefficients, sign or zero extended to 32 bits
  typedef struct packed {
    s32_t t1, t2, t3;
    s32_t p1, p2, p3, p4, p5, p6, p7, p8, p9, p10;
    s32_t h1, h2, h3, h4, h5, h6, h7;
  } coef_t;

  // word passed from the temperature front to the back end
  typedef struct packed {
    s32_t        tf;
    s32_t        tc;
    logic [19:0] rp;
    logic [15:0] rh;
  } qword_t;

  // data that rides along with the divider
  typedef struct packed {
    logic        big;
    logic [15:0] tc16;
    logic [13:0] hd;
  } dside_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int DIV_STAGES  = 32;

  localparam s32_t C_TF_OFS    = 32'sd64000;
  localparam s32_t C_P_BASE    = 32'sd1048576;
  localparam s32_t C_P_SCALE   = 32'sd3125;
  localparam s32_t C_V1_OFS    = 32'sd32768;
  localparam s32_t C_H_OFS     = 32'sd16384;
  localparam s32_t C_H_MAX     = 32'sd102400;
  localparam s32_t C_T_ROUND   = 32'sd128;
  localparam s32_t C_DIV_FIRST = 32'sh40000000;
  localparam logic [63:0] C_RECIP100 = 64'd1374389535;
  localparam logic [32:0] C_RECIP10  = 33'd52429;

  // signed divide by 100, truncating toward zero
  function automatic s32_t div100(input s32_t a);
    logic [31:0] mag;
    logic [63:0] prod;
    logic [31:0] q;
    mag  = a[31] ? (~a + 32'd1) : a;
    prod = {32'd0, mag} * C_RECIP100;
    q    = {5'd0, prod[63:37]};
    return a[31] ? s32_t'(-q) : s32_t'(q);
  endfunction

endpackage
`default_nettype wire

/* rtl/esic_front.sv */
// ----------------------------------------------------------------------------
// esic_front
// Accepts raw words and computes fine and centi-degree temperature.
// ----------------------------------------------------------------------------
`default_nettype none
module esic_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [19:0]     raw_temperature,
  input  wire logic [19:0]     raw_pressure,
  input  wire logic [15:0]     raw_humidity,
  input  wire esic_pkg::coef_t coef,
  input  wire logic            q_full,
  output logic                 push,
  output esic_pkg::qword_t     push_word
);

  logic [3:0] fv;
  logic       fen;
  esic_pkg::s32_t s1_v1, s2_m1, s2_qq, s3_v2, s3_m2, s4_tf;
  logic [19:0] rp1, rp2, rp3, rp4;
  logic [15:0] rh1, rh2, rh3, rh4;
  esic_pkg::s32_t tf5;

  // advance unless the last stage is blocked by a full queue
  assign fen      = !(fv[3] && q_full);
  assign in_stall = !fen;
  assign push     = fv[3] && !q_full;

  // track valid words
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else if (fen) begin
      fv <= {fv[2:0], in_valid};
    end
  end

  // temperature pipeline
  always_ff @(posedge clk) begin
    if (fen) begin
      s1_v1 <= esic_pkg::s32_t'({15'd0, raw_temperature[19:3]}) - (coef.t1 <<< 1);
      rp1   <= raw_pressure;
      rh1   <= raw_humidity;
      s2_m1 <= s1_v1 * coef.t2;
      s2_qq <= (s1_v1 >>> 1) * (s1_v1 >>> 1);
      rp2   <= rp1;
      rh2   <= rh1;
      s3_v2 <= s2_m1 >>> 11;
      s3_m2 <= (s2_qq >>> 12) * (coef.t3 <<< 4);
      rp3   <= rp2;
      rh3   <= rh2;
      s4_tf <= s3_v2 + (s3_m2 >>> 14);
      rp4   <= rp3;
      rh4   <= rh3;
    end
  end

  // round to centi-degrees on the way out
  assign tf5 = s4_tf * 32'sd5;
  always_comb begin
    push_word.tf = s4_tf;
    push_word.tc = (tf5 + esic_pkg::C_T_ROUND) >>> 8;
    push_word.rp = rp4;
    push_word.rh = rh4;
  end

endmodule
`default_nettype wire

/* rtl/esic_queue.sv */
// ----------------------------------------------------------------------------
// esic_queue
// Short FIFO between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module esic_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire esic_pkg::qword_t push_word,
  input  wire logic             pop,
  output esic_pkg::qword_t      head,
  output logic                  full,
  output logic                  empty
);

  esic_pkg::qword_t            mem [esic_pkg::QUEUE_DEPTH];
  logic [esic_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [esic_pkg::QPTR_W:0]   count;

  assign full  = count == (esic_pkg::QPTR_W + 1)'(esic_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  // move pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // store the word
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_word;
  end

endmodule
`default_nettype wire

/* rtl/esic_udiv.sv */
// ----------------------------------------------------------------------------
// esic_udiv
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module esic_udiv (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [31:0]      num,
  input  wire logic [31:0]      den,
  input  wire esic_pkg::dside_t side_in,
  output logic                  out_valid,
  output logic [31:0]           quo,
  output esic_pkg::dside_t      side_out
);

  localparam int N = esic_pkg::DIV_STAGES;

  logic [31:0]      rem_r [N];
  logic [31:0]      num_r [N];
  logic [31:0]      den_r [N];
  logic [31:0]      quo_r [N];
  esic_pkg::dside_t side_r [N];
  logic [N-1:0]     vld;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [31:0]      r_in, n_in, d_in, q_in;
    esic_pkg::dside_t s_in;
    logic [32:0]      trial, diff;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign n_in = num;
      assign d_in = den;
      assign q_in = '0;
      assign s_in = side_in;
    end else begin : g_next
      assign r_in = rem_r[k-1];
      assign n_in = num_r[k-1];
      assign d_in = den_r[k-1];
      assign q_in = quo_r[k-1];
      assign s_in = side_r[k-1];
    end

    // shift in one numerator bit and try the subtract
    assign trial = {r_in, n_in[31]};
    assign diff  = trial - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= {1'b0, d_in}) begin
          rem_r[k] <= diff[31:0];
          quo_r[k] <= {q_in[30:0], 1'b1};
        end else begin
          rem_r[k] <= trial[31:0];
          quo_r[k] <= {q_in[30:0], 1'b0};
        end
        num_r[k]  <= {n_in[30:0], 1'b0};
        den_r[k]  <= d_in;
        side_r[k] <= s_in;
      end
    end
  end

  assign out_valid = vld[N-1];
  assign quo       = quo_r[N-1];
  assign side_out  = side_r[N-1];

endmodule
`default_nettype wire

/* rtl/esic_back.sv */
// ----------------------------------------------------------------------------
// esic_back
// Humidity and pressure compensation pipeline with the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module esic_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire esic_pkg::coef_t  coef,
  input  wire logic             q_empty,
  input  wire esic_pkg::qword_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic signed [15:0]    temperature_centi,
  output logic [13:0]           humidity_centi,
  output logic signed [31:0]    pressure_pa
);

  logic        en;
  logic [10:0] bv;
  logic [3:0]  cv;

  // stage registers of the humidity and pressure paths
  esic_pkg::s32_t b1_a3, b1_a4, b1_a5, b1_a7, b1_pv1, b1_tc;
  logic [19:0]    b1_rp, b2_rp, b3_rp, b4_rp;
  logic [15:0]    b1_rh, b2_rh, b3_rh, b4_rh;
  esic_pkg::s32_t b2_d3, b2_d4, b2_d5, b2_d7, b2_qq, b2_m5, b2_m2, b2_tc;
  esic_pkg::s32_t b3_a6, b3_pa, b3_pb, b3_d3, b3_d4, b3_d7, b3_m5, b3_m2, b3_tc;
  esic_pkg::s32_t b4_d6, b4_v2p, b4_v1p, b4_d3, b4_d4, b4_d7, b4_tc;
  esic_pkg::s32_t b5_hv1, b5_hv2s, b5_v4, b5_den, b5_pc0, b5_tc;
  esic_pkg::s32_t b6_hm, b6_pcm, b6_hv1, b6_v4, b6_den, b6_tc;
  esic_pkg::s32_t b7_v3, b7_num, b7_v4, b7_den, b7_tc;
  esic_pkg::s32_t b8_sq, b8_v3, b8_v4, b8_num, b8_den, b8_tc;
  esic_pkg::s32_t b9_v6m, b9_v3, b9_num, b9_den, b9_tc;
  esic_pkg::s32_t b10_hc, b10_num, b10_den, b10_tc;
  logic           b7_big, b8_big, b9_big, b10_big;
  logic [13:0]    b11_hd;
  logic [31:0]    b11_num, b11_den;
  logic           b11_big;
  logic [15:0]    b11_tc16;

  esic_pkg::s32_t b10_sum, b10_raw;
  logic [32:0]    b11_prod;
  esic_pkg::dside_t side_in, side_out;
  logic           dv_valid;
  logic [31:0]    dv_quo;

  esic_pkg::s32_t c1_pc, c2_sa, c2_cm, c2_r2, c2_pc;
  esic_pkg::s32_t c3_v1m, c3_v2, c3_r3, c3_pc, c4_v1, c4_v2, c4_r4, c4_pc;
  logic [15:0]    c1_tc, c2_tc, c3_tc, c4_tc;
  logic [13:0]    c1_hd, c2_hd, c3_hd, c4_hd;

  // hold everything while a result waits
  assign en  = !out_valid || !out_stall;
  assign pop = en && !q_empty;

  // valid chains
  always_ff @(posedge clk) begin
    if (rst) begin
      bv        <= '0;
      cv        <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      bv        <= {bv[9:0], !q_empty};
      cv        <= {cv[2:0], dv_valid};
      out_valid <= cv[3];
    end
  end

  // humidity clamp
  assign b10_sum = b9_v3 + (b9_v6m >>> 1);
  assign b10_raw = b10_sum >>> 12;
  assign b11_prod = {16'd0, b10_hc[16:0]} * esic_pkg::C_RECIP10;

  // stages ahead of the divider
  always_ff @(posedge clk) begin
    if (en) begin
      b1_a3  <= head.tc * coef.h3;
      b1_a4  <= head.tc * coef.h4;
      b1_a5  <= head.tc * coef.h5;
      b1_a7  <= head.tc * coef.h7;
      b1_pv1 <= (head.tf >>> 1) - esic_pkg::C_TF_OFS;
      b1_tc  <= head.tc;
      b1_rp  <= head.rp;
      b1_rh  <= head.rh;

      b2_d3 <= esic_pkg::div100(b1_a3);
      b2_d4 <= esic_pkg::div100(b1_a4);
      b2_d5 <= esic_pkg::div100(b1_a5);
      b2_d7 <= esic_pkg::div100(b1_a7);
      b2_qq <= (b1_pv1 >>> 2) * (b1_pv1 >>> 2);
      b2_m5 <= b1_pv1 * coef.p5;
      b2_m2 <= coef.p2 * b1_pv1;
      b2_tc <= b1_tc;
      b2_rp <= b1_rp;
      b2_rh <= b1_rh;

      b3_a6 <= b2_tc * b2_d5;
      b3_pa <= (b2_qq >>> 11) * coef.p6;
      b3_pb <= (b2_qq >>> 13) * (coef.p3 <<< 5);
      b3_d3 <= b2_d3;
      b3_d4 <= b2_d4;
      b3_d7 <= b2_d7;
      b3_m5 <= b2_m5;
      b3_m2 <= b2_m2;
      b3_tc <= b2_tc;
      b3_rp <= b2_rp;
      b3_rh <= b2_rh;

      b4_d6  <= esic_pkg::div100(b3_a6 >>> 6);
      b4_v2p <= ((((b3_pa >>> 2) + (b3_m5 <<< 1)) >>> 2) + (coef.p4 <<< 16));
      b4_v1p <= esic_pkg::C_V1_OFS + (((b3_pb >>> 3) + (b3_m2 >>> 1)) >>> 18);
      b4_d3  <= b3_d3;
      b4_d4  <= b3_d4;
      b4_d7  <= b3_d7;
      b4_tc  <= b3_tc;
      b4_rp  <= b3_rp;
      b4_rh  <= b3_rh;

      b5_hv1  <= esic_pkg::s32_t'({16'd0, b4_rh}) - (coef.h1 <<< 4) - (b4_d3 >>> 1);
      b5_hv2s <= b4_d4 + b4_d6 + esic_pkg::C_H_OFS;
      b5_v4   <= ((coef.h6 <<< 7) + b4_d7) >>> 4;
      b5_den  <= (b4_v1p * coef.p1) >>> 15;
      b5_pc0  <= (esic_pkg::C_P_BASE - esic_pkg::s32_t'({12'd0, b4_rp})) - (b4_v2p >>> 12);
      b5_tc   <= b4_tc;

      b6_hm  <= coef.h2 * b5_hv2s;
      b6_pcm <= b5_pc0 * esic_pkg::C_P_SCALE;
      b6_hv1 <= b5_hv1;
      b6_v4  <= b5_v4;
      b6_den <= b5_den;
      b6_tc  <= b5_tc;

      // large terms divide first and double afterward
      b7_v3  <= b6_hv1 * (b6_hm >>> 10);
      b7_big <= b6_pcm >= esic_pkg::C_DIV_FIRST;
      b7_num <= (b6_pcm >= esic_pkg::C_DIV_FIRST) ? b6_pcm : (b6_pcm <<< 1);
      b7_v4  <= b6_v4;
      b7_den <= b6_den;
      b7_tc  <= b6_tc;

      b8_sq  <= (b7_v3 >>> 14) * (b7_v3 >>> 14);
      b8_v3  <= b7_v3;
      b8_v4  <= b7_v4;
      b8_num <= b7_num;
      b8_den <= b7_den;
      b8_big <= b7_big;
      b8_tc  <= b7_tc;

      b9_v6m <= b8_v4 * (b8_sq >>> 10);
      b9_v3  <= b8_v3;
      b9_num <= b8_num;
      b9_den <= b8_den;
      b9_big <= b8_big;
      b9_tc  <= b8_tc;

      priority if (b10_raw > esic_pkg::C_H_MAX) begin
        b10_hc <= esic_pkg::C_H_MAX;
      end else if (b10_raw < 0) begin
        b10_hc <= '0;
      end else begin
        b10_hc <= b10_raw;
      end
      b10_num <= b9_num;
      b10_den <= b9_den;
      b10_big <= b9_big;
      b10_tc  <= b9_tc;

      b11_hd   <= b11_prod[32:19];
      b11_num  <= b10_num;
      b11_den  <= b10_den;
      b11_big  <= b10_big;
      b11_tc16 <= b10_tc[15:0];
    end
  end

  assign side_in.big  = b11_big;
  assign side_in.tc16 = b11_tc16;
  assign side_in.hd   = b11_hd;

  esic_udiv u_udiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (bv[10]),
    .num       (b11_num),
    .den       (b11_den),
    .side_in   (side_in),
    .out_valid (dv_valid),
    .quo       (dv_quo),
    .side_out  (side_out)
  );

  // pressure correction after the divide
  always_ff @(posedge clk) begin
    if (en) begin
      c1_pc <= side_out.big ? esic_pkg::s32_t'({dv_quo[30:0], 1'b0})
                            : esic_pkg::s32_t'(dv_quo);
      c1_tc <= side_out.tc16;
      c1_hd <= side_out.hd;

      c2_sa <= (c1_pc >>> 3) * (c1_pc >>> 3);
      c2_cm <= (c1_pc >>> 2) * coef.p8;
      c2_r2 <= (c1_pc >>> 8) * (c1_pc >>> 8);
      c2_pc <= c1_pc;
      c2_tc <= c1_tc;
      c2_hd <= c1_hd;

      c3_v1m <= coef.p9 * (c2_sa >>> 13);
      c3_v2  <= c2_cm >>> 13;
      c3_r3  <= c2_r2 * (c2_pc >>> 8);
      c3_pc  <= c2_pc;
      c3_tc  <= c2_tc;
      c3_hd  <= c2_hd;

      c4_v1 <= c3_v1m >>> 12;
      c4_r4 <= c3_r3 * coef.p10;
      c4_v2 <= c3_v2;
      c4_pc <= c3_pc;
      c4_tc <= c3_tc;
      c4_hd <= c3_hd;

      pressure_pa <= c4_pc
        + ((c4_v1 + c4_v2 + (c4_r4 >>> 17) + (coef.p7 <<< 7)) >>> 4);
      temperature_centi <= c4_tc;
      humidity_centi    <= c4_hd;
    end
  end

endmodule
`default_nettype wire

/* rtl/env_sensor_integer_compensation.sv */
// ----------------------------------------------------------------------------
// env_sensor_integer_compensation
// Integer temperature, humidity and pressure compensation of raw readings.
// ----------------------------------------------------------------------------
// The block takes one word of raw readings per clock while in_stall is low and
// returns one word of compensated temperature, humidity and pressure for each,
// in order; throughput is one word per cycle when neither side stalls. The
// path runs through a 4-stage temperature front end, the queue, the multiplier
// stages of the humidity and pressure paths and the 32-stage pressure divider.
// A four-entry queue separates the front from the back end so each can stall
// on its own. Calibration is written over the APB port at byte address 8*i
// and must only change while no words are in flight.
`default_nettype none
module env_sensor_integer_compensation (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [5:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic [63:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [19:0]        raw_temperature,
  input  wire logic [19:0]        raw_pressure,
  input  wire logic [15:0]        raw_humidity,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      temperature_centi,
  output logic [13:0]             humidity_centi,
  output logic signed [31:0]      pressure_pa
);

  logic [39:0] temp_cal;
  logic [55:0] press_cal_a;
  logic [47:0] press_cal_b;
  logic [23:0] press_cal_c;
  logic [47:0] hum_cal_a;
  logic [15:0] hum_cal_b;

  esic_pkg::reg_idx_t reg_idx;
  esic_pkg::coef_t    coef;
  esic_pkg::qword_t   push_word, head;
  logic               push, pop, q_full, q_empty;

  assign pready  = 1'b1;
  assign reg_idx = esic_pkg::reg_idx_t'(paddr[5:3]);

  // write calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal    <= '0;
      press_cal_a <= '0;
      press_cal_b <= '0;
      press_cal_c <= '0;
      hum_cal_a   <= '0;
      hum_cal_b   <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        esic_pkg::REG_TEMP_CAL:    temp_cal    <= pwdata[39:0];
        esic_pkg::REG_PRESS_CAL_A: press_cal_a <= pwdata[55:0];
        esic_pkg::REG_PRESS_CAL_B: press_cal_b <= pwdata[47:0];
        esic_pkg::REG_PRESS_CAL_C: press_cal_c <= pwdata[23:0];
        esic_pkg::REG_HUM_CAL_A:   hum_cal_a   <= pwdata[47:0];
        esic_pkg::REG_HUM_CAL_B:   hum_cal_b   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      esic_pkg::REG_TEMP_CAL:    prdata = {24'd0, temp_cal};
      esic_pkg::REG_PRESS_CAL_A: prdata = {8'd0, press_cal_a};
      esic_pkg::REG_PRESS_CAL_B: prdata = {16'd0, press_cal_b};
      esic_pkg::REG_PRESS_CAL_C: prdata = {40'd0, press_cal_c};
      esic_pkg::REG_HUM_CAL_A:   prdata = {16'd0, hum_cal_a};
      esic_pkg::REG_HUM_CAL_B:   prdata = {48'd0, hum_cal_b};
      default:                   prdata = '0;
    endcase
  end

  // unpack coefficients
  always_comb begin
    coef.t1  = esic_pkg::s32_t'({16'd0, temp_cal[15:0]});
    coef.t2  = esic_pkg::s32_t'({{16{temp_cal[31]}}, temp_cal[31:16]});
    coef.t3  = esic_pkg::s32_t'({{24{temp_cal[39]}}, temp_cal[39:32]});
    coef.p1  = esic_pkg::s32_t'({16'd0, press_cal_a[15:0]});
    coef.p2  = esic_pkg::s32_t'({{16{press_cal_a[31]}}, press_cal_a[31:16]});
    coef.p3  = esic_pkg::s32_t'({{24{press_cal_a[39]}}, press_cal_a[39:32]});
    coef.p4  = esic_pkg::s32_t'({{16{press_cal_a[55]}}, press_cal_a[55:40]});
    coef.p5  = esic_pkg::s32_t'({{16{press_cal_b[15]}}, press_cal_b[15:0]});
    coef.p6  = esic_pkg::s32_t'({{24{press_cal_b[23]}}, press_cal_b[23:16]});
    coef.p7  = esic_pkg::s32_t'({{24{press_cal_b[31]}}, press_cal_b[31:24]});
    coef.p8  = esic_pkg::s32_t'({{16{press_cal_b[47]}}, press_cal_b[47:32]});
    coef.p9  = esic_pkg::s32_t'({{16{press_cal_c[15]}}, press_cal_c[15:0]});
    coef.p10 = esic_pkg::s32_t'({24'd0, press_cal_c[23:16]});
    coef.h1  = esic_pkg::s32_t'({20'd0, hum_cal_a[11:0]});
    coef.h2  = esic_pkg::s32_t'({20'd0, hum_cal_a[23:12]});
    coef.h3  = esic_pkg::s32_t'({{24{hum_cal_a[31]}}, hum_cal_a[31:24]});
    coef.h4  = esic_pkg::s32_t'({{24{hum_cal_a[39]}}, hum_cal_a[39:32]});
    coef.h5  = esic_pkg::s32_t'({{24{hum_cal_a[47]}}, hum_cal_a[47:40]});
    coef.h6  = esic_pkg::s32_t'({24'd0, hum_cal_b[7:0]});
    coef.h7  = esic_pkg::s32_t'({{24{hum_cal_b[15]}}, hum_cal_b[15:8]});
  end

  esic_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .raw_temperature (raw_temperature),
    .raw_pressure    (raw_pressure),
    .raw_humidity    (raw_humidity),
    .coef            (coef),
    .q_full          (q_full),
    .push            (push),
    .push_word       (push_word)
  );

  esic_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  esic_back u_back (
    .clk               (clk),
    .rst               (rst),
    .coef              (coef),
    .q_empty           (q_empty),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi),
    .pressure_pa       (pressure_pa)
  );

endmodule
`default_nettype wire

/* rtl/esic_checker.sv */
// ----------------------------------------------------------------------------
// esic_checker
// Port-level checks on the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "env_sensor_integer_compensation_macros.svh"
module esic_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] pressure_pa,
  input wire logic [13:0]        humidity_centi
);

  // a stalled result stays
  `ESIC_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid)
  // and keeps its pressure word
  `ESIC_ASSERT(a_out_stable, clk, rst, out_valid && out_stall |=> $stable(pressure_pa))
  // nothing leaves right after reset
  `ESIC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)
  // humidity never exceeds the clamp
  `ESIC_ASSERT(a_hum_range, clk, rst, out_valid |-> humidity_centi <= 14'd10240)

endmodule

bind env_sensor_integer_compensation esic_checker u_esic_checker (.*);
`default_nettype wire
